// ===== hdl/ldac_pkg.sv =====
package ldac_pkg;

  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int TABLE_ADDR_BITS_DEF = 8;
  localparam int MAX_TAB_BITS        = 12;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;

  localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd394566;
  localparam logic [31:0] LOG2_PER_DB_Q24 = 32'd2786635;
  localparam logic [15:0] FLOOR_DB_Q88    = 16'd30720;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_INV_RATIO = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_MAKEUP    = 3'd4
  } ldac_reg_e;

  typedef struct packed {
    logic start;
    logic keep_acc;
  } mul_ctl_t;

  function automatic logic [63:0] ldac_isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // log2(1+f) in Q0.16 by repeated squaring
  function automatic logic [15:0] ldac_log_entry(input int abits, input int k);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'(1 << abits) + 64'(k)) << (30 - abits);
    r = 16'd0;
    for (int j = 15; j >= 0; j--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x    = x >> 1;
        r[j] = 1'b1;
      end
    end
    return r;
  endfunction

  // 2^f in Q2.30 as a product of repeated square roots of two
  function automatic logic [31:0] ldac_exp_entry(input int abits, input int k);
    logic [63:0] roots [MAX_TAB_BITS+1];
    logic [63:0] y;
    roots[0] = 64'd2 << 30;
    for (int j = 1; j <= MAX_TAB_BITS; j++) begin
      if (j <= abits) roots[j] = ldac_isqrt(roots[j-1] << 30);
      else roots[j] = 64'd0;
    end
    y = 64'd1 << 30;
    for (int j = 0; j < MAX_TAB_BITS; j++) begin
      if (j < abits && ((k >> j) & 1) != 0) y = (y * roots[abits-j]) >> 30;
    end
    return y[31:0];
  endfunction

endpackage

// ===== hdl/ldac_mul.sv =====
module ldac_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ldac_pkg::mul_ctl_t             ctl_i,
  input  logic [ldac_pkg::MUL_A_W-1:0]   mcand_i,
  input  logic [ldac_pkg::MUL_B_W-1:0]   mplier_i,
  input  logic [ldac_pkg::MUL_A_W-1:0]   acc_init_i,
  output logic [ldac_pkg::MUL_A_W-1:0]   acc_o,
  output logic                           done_o
);
  import ldac_pkg::*;

  logic                 busy_q;
  logic [MUL_A_W-1:0]   mcand_q;
  logic [MUL_B_W-1:0]   mplier_q;
  logic [MUL_A_W-1:0]   acc_q;

  // shift-add, one multiplier bit per cycle, stops once no bits remain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q && mplier_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      if (!ctl_i.keep_acc) acc_q <= acc_init_i;
    end else if (busy_q && mplier_q != '0) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = busy_q && (mplier_q == '0);

endmodule

// ===== hdl/ldac_norm.sv =====
module ldac_norm #(
  parameter int W = ldac_pkg::SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          data_i,
  output logic [W-1:0]          norm_o,
  output logic [$clog2(W)-1:0]  count_o,
  output logic                  done_o
);
  logic                 busy_q;
  logic [W-1:0]         norm_q;
  logic [$clog2(W)-1:0] count_q;

  // one bit position per cycle until the leading one reaches the top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && norm_q[W-1]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      norm_q  <= data_i;
      count_q <= '0;
    end else if (busy_q && !norm_q[W-1]) begin
      norm_q  <= norm_q << 1;
      count_q <= count_q + 1'b1;
    end
  end

  assign norm_o  = norm_q;
  assign count_o = count_q;
  assign done_o  = busy_q && norm_q[W-1];

endmodule

// ===== hdl/log_domain_audio_compressor.sv =====
// Feedforward log-domain compressor, one signed sample in, one sample out.
// Input channel: in_valid_i / in_stall_o with sample_in_i; a transfer happens
// on a clock edge with valid high and stall low. Output channel: out_valid_o /
// out_stall_i with sample_out_o and gain_reduction_db_o, one result per input.
// Registers are written through cfg_valid_i / cfg_ready_o, cfg_index_i and
// cfg_data_i; the user must write them only while no sample is in flight,
// which the block itself does not enforce. cfg_ready_o is always high.
// One sample is processed at a time: the bit-serial normalizer finds its
// leading-zero count (at most SAMPLE_BITS-1), then the shared shift-add
// multiplier makes six passes (level, curve, two smoothing, gain, apply) with
// multiplier operands of 19, up to 16, up to 16, up to 17, 22 bits and the
// sample magnitude width; the exponent table is read before the apply pass.
// A tiny magnitude skips the normalizer and the level pass, a level below
// the threshold skips the curve pass. The next input transfer can be taken
// in the same cycle as the result is first offered.
// The result sits in an output register, so a stalled receiver does not block
// the next input transfer; the sequencer waits only when a second finished
// result meets a full output register. Reset clears the registers to their
// defaults, the smoothed reduction to 0 dB and empties the output register.
module log_domain_audio_compressor #(
  parameter int SAMPLE_BITS     = ldac_pkg::SAMPLE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = ldac_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  output logic [13:0]                         gain_reduction_db_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ldac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ldac_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ldac_pkg::*;

  localparam int SH_W     = $clog2(SAMPLE_BITS);
  localparam int TAB_SIZE = 1 << TABLE_ADDR_BITS;
  localparam logic [63:0] HALF = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] TINY_MAX =
    SAMPLE_BITS'(((64'd1 << (SAMPLE_BITS - 1)) - 64'd1) / 64'd1000000);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LVL, S_LVLW, S_CURVE, S_CURVEW, S_SMOOTH, S_SM1,
    S_SM2, S_GAIN, S_GAINW, S_EXP, S_APPLY, S_APPLYW, S_OUT
  } state_e;

  // configuration
  logic signed [14:0] thr_q;
  logic [15:0]        inv_ratio_q;
  logic [15:0]        attack_q;
  logic [15:0]        release_q;
  logic [12:0]        makeup_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      inv_ratio_q <= 16'd32768;
      attack_q    <= 16'd65445;
      release_q   <= 16'd65522;
      makeup_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ldac_reg_e'(cfg_index_i))
        REG_THRESHOLD: thr_q       <= $signed(cfg_data_i[14:0]);
        REG_INV_RATIO: inv_ratio_q <= cfg_data_i;
        REG_ATTACK:    attack_q    <= cfg_data_i;
        REG_RELEASE:   release_q   <= cfg_data_i;
        REG_MAKEUP:    makeup_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // constant tables
  logic [15:0] log_tab [TAB_SIZE];
  logic [31:0] exp_tab [TAB_SIZE];

  for (genvar k = 0; k < TAB_SIZE; k++) begin : g_tab
    assign log_tab[k] = ldac_log_entry(TABLE_ADDR_BITS, k);
    assign exp_tab[k] = ldac_exp_entry(TABLE_ADDR_BITS, k);
  end

  state_e                  state_q;
  logic [SAMPLE_BITS-1:0]  mag_q;
  logic                    neg_q;
  logic [SH_W-1:0]         shifts_q;
  logic [15:0]             log_q;
  logic signed [16:0]      xg_q;
  logic [16:0]             d_q;
  logic [14:0]             xl_q;
  logic [15:0]             alpha_q;
  logic [23:0]             state_red_q;
  logic                    gneg_q;
  logic signed [9:0]       ipart_q;
  logic [15:0]             frac_q;
  logic [31:0]             c_q;
  logic [5:0]              sh_q;
  logic                    out_valid_q;
  logic [SAMPLE_BITS-1:0]  res_q;
  logic [SAMPLE_BITS-1:0]  out_sample_q;
  logic [13:0]             out_gr_q;

  mul_ctl_t                mul_ctl;
  logic [MUL_A_W-1:0]      mul_mcand;
  logic [MUL_B_W-1:0]      mul_mplier;
  logic [MUL_A_W-1:0]      mul_init;
  logic [MUL_A_W-1:0]      mul_acc;
  logic                    mul_done;

  logic                    norm_start;
  logic [SAMPLE_BITS-1:0]  norm_data;
  logic [SH_W-1:0]         norm_cnt;
  logic                    norm_done;

  logic                    accept;
  logic [SAMPLE_BITS-1:0]  s_u;
  logic [SAMPLE_BITS-1:0]  mag_d;
  logic                    tiny;
  logic [SH_W+15:0]        nl;
  logic signed [16:0]      thr_ext;
  logic                    over_thr;
  logic [16:0]             d_c;
  logic [22:0]             target;
  logic [15:0]             alpha_sel;
  logic signed [25:0]      g;
  logic [24:0]             gmag;

  assign accept = in_valid_i && !in_stall_o;
  assign s_u    = sample_in_i;
  assign mag_d  = s_u[SAMPLE_BITS-1] ? (~s_u + 1'b1) : s_u;
  assign tiny   = (mag_d <= TINY_MAX);

  assign nl        = {shifts_q, 16'h0000} - (SH_W+16)'(log_q);
  assign thr_ext   = 17'(thr_q);
  assign over_thr  = (xg_q >= thr_ext);
  assign d_c       = 17'(xg_q - thr_ext);
  assign target    = {xl_q, 8'h00};
  assign alpha_sel = ({1'b0, target} > state_red_q) ? attack_q : release_q;
  assign g         = $signed({5'b0, makeup_q, 8'h00}) - $signed({2'b0, state_red_q});
  assign gmag      = g[25] ? 25'(-g) : 25'(g);

  // operand selection for the shared multiplier
  always_comb begin
    mul_ctl    = '0;
    mul_mcand  = '0;
    mul_mplier = '0;
    mul_init   = '0;
    norm_start = 1'b0;
    case (state_q)
      S_IDLE: norm_start = accept && !tiny;
      S_LVL: begin
        mul_ctl.start = 1'b1;
        mul_mcand     = MUL_A_W'(nl);
        mul_mplier    = DB_PER_LOG2_Q16;
        mul_init      = 64'd1 << 23;
      end
      S_CURVE: begin
        mul_ctl.start = over_thr;
        mul_mcand     = MUL_A_W'(d_c);
        mul_mplier    = MUL_B_W'(inv_ratio_q);
        mul_init      = 64'd1 << 14;
      end
      S_SMOOTH: begin
        mul_ctl.start = 1'b1;
        mul_mcand     = MUL_A_W'(state_red_q);
        mul_mplier    = MUL_B_W'(alpha_sel);
        mul_init      = 64'd1 << 15;
      end
      S_SM1: begin
        // second product accumulates onto the first
        mul_ctl.start    = mul_done;
        mul_ctl.keep_acc = 1'b1;
        mul_mcand        = MUL_A_W'(target);
        mul_mplier       = MUL_B_W'(17'h10000 - 17'(alpha_q));
      end
      S_GAIN: begin
        mul_ctl.start = 1'b1;
        mul_mcand     = MUL_A_W'(gmag);
        mul_mplier    = LOG2_PER_DB_Q24;
        mul_init      = 64'd1 << 23;
      end
      S_APPLY: begin
        mul_ctl.start = 1'b1;
        mul_mcand     = MUL_A_W'(c_q);
        mul_mplier    = MUL_B_W'(mag_q);
        mul_init      = 64'd1 << (sh_q - 6'd1);
      end
      default: ;
    endcase
  end

  ldac_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mul_ctl),
    .mcand_i    (mul_mcand),
    .mplier_i   (mul_mplier),
    .acc_init_i (mul_init),
    .acc_o      (mul_acc),
    .done_o     (mul_done)
  );

  ldac_norm #(.W(SAMPLE_BITS)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .data_i  (mag_d),
    .norm_o  (norm_data),
    .count_o (norm_cnt),
    .done_o  (norm_done)
  );

  logic [15:0]        db_c;
  logic [18:0]        kept_c;
  logic [31:0]        emag_c;
  logic signed [9:0]  ip_c;
  logic signed [10:0] shv_c;
  logic [63:0]        res_c;
  logic [63:0]        sat_c;

  assign db_c   = mul_acc[39:24];
  assign kept_c = mul_acc[33:15];
  assign emag_c = mul_acc[55:24];
  assign ip_c   = $signed({2'b00, emag_c[23:16]});
  assign shv_c  = 11'sd30 - 11'(ipart_q);
  assign res_c  = mul_acc >> sh_q;
  assign sat_c  = neg_q ? ((res_c > HALF) ? HALF : res_c)
                        : ((res_c > HALF - 64'd1) ? HALF - 64'd1 : res_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      state_red_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            mag_q <= mag_d;
            neg_q <= s_u[SAMPLE_BITS-1];
            if (tiny) begin
              xg_q    <= -$signed({1'b0, FLOOR_DB_Q88});
              state_q <= S_CURVE;
            end else begin
              state_q <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (norm_done) begin
            log_q    <= log_tab[norm_data[SAMPLE_BITS-2 -: TABLE_ADDR_BITS]];
            shifts_q <= norm_cnt;
            state_q  <= S_LVL;
          end
        end
        S_LVL: state_q <= S_LVLW;
        S_LVLW: begin
          if (mul_done) begin
            xg_q    <= (db_c > FLOOR_DB_Q88) ? -$signed({1'b0, FLOOR_DB_Q88})
                                             : -$signed({1'b0, db_c});
            state_q <= S_CURVE;
          end
        end
        S_CURVE: begin
          if (over_thr) begin
            d_q     <= d_c;
            state_q <= S_CURVEW;
          end else begin
            xl_q    <= '0;
            state_q <= S_SMOOTH;
          end
        end
        S_CURVEW: begin
          if (mul_done) begin
            xl_q    <= ({2'b00, d_q} > kept_c) ? 15'(d_q - 17'(kept_c)) : 15'd0;
            state_q <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          alpha_q <= alpha_sel;
          state_q <= S_SM1;
        end
        S_SM1: if (mul_done) state_q <= S_SM2;
        S_SM2: begin
          if (mul_done) begin
            state_red_q <= mul_acc[39:16];
            state_q     <= S_GAIN;
          end
        end
        S_GAIN: begin
          gneg_q  <= g[25];
          state_q <= S_GAINW;
        end
        S_GAINW: begin
          if (mul_done) begin
            // negative exponent: floor integer part, fraction folded upward
            if (gneg_q && emag_c[15:0] != 16'h0000) begin
              ipart_q <= -ip_c - 10'sd1;
              frac_q  <= 16'(17'h10000 - 17'(emag_c[15:0]));
            end else begin
              ipart_q <= gneg_q ? -ip_c : ip_c;
              frac_q  <= emag_c[15:0];
            end
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          c_q <= exp_tab[frac_q[15 -: TABLE_ADDR_BITS]];
          if (shv_c < 11'sd1) sh_q <= 6'd1;
          else if (shv_c > 11'sd63) sh_q <= 6'd63;
          else sh_q <= shv_c[5:0];
          state_q <= S_APPLY;
        end
        S_APPLY: state_q <= S_APPLYW;
        S_APPLYW: begin
          if (mul_done) begin
            res_q   <= neg_q ? SAMPLE_BITS'(~sat_c + 64'd1) : sat_c[SAMPLE_BITS-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= res_q;
            out_gr_q     <= (state_red_q[23:8] > 16'd16383) ? 14'h3FFF
                                                             : state_red_q[21:8];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign sample_out_o        = $signed(out_sample_q);
  assign gain_reduction_db_o = out_gr_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a sample is still in flight");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result appeared without the sequencer finishing");

  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_LVLW || state_q == S_CURVEW || state_q == S_SM1 ||
                  state_q == S_SM2 || state_q == S_GAINW || state_q == S_APPLYW))
    else $error("multiplier finished outside a wait state");

  a_norm_done_in_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> (state_q == S_NORM))
    else $error("normalizer finished outside its state");

endmodule
